// ===== hw/rtl/fpm_pkg.sv =====
package fpm_pkg;

  localparam int FR_W    = 16;   // Fresnel part, Q2.14
  localparam int SKY_W   = 24;   // sky part
  localparam int PWR_W   = 6;    // exponent register
  localparam int NCELL   = PWR_W; // one cell per exponent bit
  localparam int FRAC    = 14;

  localparam logic signed [FR_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic [PWR_W-1:0]       POWER_RESET = 6'd1;

  // Register indexes on the configuration port
  localparam logic REG_POWER = 1'b0;

  typedef struct packed {
    logic signed [FR_W-1:0] re;
    logic signed [FR_W-1:0] im;
  } cplx16_t;

  typedef struct packed {
    logic signed [SKY_W-1:0] re;
    logic signed [SKY_W-1:0] im;
  } cplx24_t;

  // Data carried from cell to cell
  typedef struct packed {
    logic signed [FR_W-1:0]  acc_re;
    logic signed [FR_W-1:0]  acc_im;
    logic signed [FR_W-1:0]  base_re;
    logic signed [FR_W-1:0]  base_im;
    logic signed [SKY_W-1:0] sky_re;
    logic signed [SKY_W-1:0] sky_im;
    logic                    unchanged;
  } stage_t;

  function automatic logic signed [FR_W-1:0] sat16(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [FR_W-1:0] r;
    t = v >>> FRAC;
    if (t > 34'sd32767) begin
      r = 16'sh7FFF;
    end else if (t < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = t[FR_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SKY_W-1:0] sat24(input logic signed [41:0] v);
    logic signed [41:0] t;
    logic signed [SKY_W-1:0] r;
    t = v >>> FRAC;
    if (t > 42'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (t < -42'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = t[SKY_W-1:0];
    end
    return r;
  endfunction

  // Q2.14 complex product, round half up, saturate
  function automatic cplx16_t cmul_q14(input logic signed [FR_W-1:0] ar,
                                       input logic signed [FR_W-1:0] ai,
                                       input logic signed [FR_W-1:0] br,
                                       input logic signed [FR_W-1:0] bi);
    logic signed [31:0] p_rr, p_ii, p_ri, p_ir;
    logic signed [33:0] s_re, s_im;
    cplx16_t r;
    p_rr = ar * br;
    p_ii = ai * bi;
    p_ri = ar * bi;
    p_ir = ai * br;
    s_re = 34'(p_rr) - 34'(p_ii) + 34'sd8192;
    s_im = 34'(p_ri) + 34'(p_ir) + 34'sd8192;
    r.re = sat16(s_re);
    r.im = sat16(s_im);
    return r;
  endfunction

  // Sky times Q2.14 factor, round half up, saturate to 24 bits
  function automatic cplx24_t cmul_sky(input logic signed [SKY_W-1:0] sr,
                                       input logic signed [SKY_W-1:0] si,
                                       input logic signed [FR_W-1:0]  ar,
                                       input logic signed [FR_W-1:0]  ai);
    logic signed [39:0] p_rr, p_ii, p_ri, p_ir;
    logic signed [41:0] s_re, s_im;
    cplx24_t r;
    p_rr = sr * ar;
    p_ii = si * ai;
    p_ri = sr * ai;
    p_ir = si * ar;
    s_re = 42'(p_rr) - 42'(p_ii) + 42'sd8192;
    s_im = 42'(p_ri) + 42'(p_ir) + 42'sd8192;
    r.re = sat24(s_re);
    r.im = sat24(s_im);
    return r;
  endfunction

endpackage

// ===== hw/rtl/fpm_cell.sv =====
module fpm_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            pw_bit,
  input  logic            in_valid,
  input  fpm_pkg::stage_t d_in,
  input  logic            down_ready,
  output logic            up_ready,
  output logic            valid,
  output fpm_pkg::stage_t q
);
  import fpm_pkg::*;

  logic    adv;
  cplx16_t prod;
  cplx16_t sq;
  stage_t  q_next;

  // advance when empty or when the next cell takes our item
  assign adv      = !valid || down_ready;
  assign up_ready = adv;

  always_comb begin
    prod   = cmul_q14(d_in.acc_re, d_in.acc_im, d_in.base_re, d_in.base_im);
    sq     = cmul_q14(d_in.base_re, d_in.base_im, d_in.base_re, d_in.base_im);
    q_next = d_in;
    if (pw_bit) begin
      q_next.acc_re = prod.re;
      q_next.acc_im = prod.im;
    end
    q_next.base_re = sq.re;
    q_next.base_im = sq.im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      q <= q_next;
    end
  end

endmodule

// ===== hw/rtl/fpm_out.sv =====
module fpm_out (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  fpm_pkg::stage_t                d_in,
  output logic                           up_ready,
  output logic                           valid,
  input  logic                           stall,
  output logic signed [fpm_pkg::SKY_W-1:0] re,
  output logic signed [fpm_pkg::SKY_W-1:0] im,
  output logic                           unchanged
);
  import fpm_pkg::*;

  logic    adv;
  cplx24_t prod;

  assign adv      = !valid || !stall;
  assign up_ready = adv;

  assign prod = cmul_sky(d_in.sky_re, d_in.sky_im, d_in.acc_re, d_in.acc_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  // pass the sky through when flagged, else take the product
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      unchanged <= d_in.unchanged;
      if (d_in.unchanged) begin
        re <= d_in.sky_re;
        im <= d_in.sky_im;
      end else begin
        re <= prod.re;
        im <= prod.im;
      end
    end
  end

endmodule

// ===== hw/rtl/fresnel_power_multiply.sv =====
// Pipeline: six power cells, one per exponent bit, then the sky multiply / output register.
// Throughput: one item per cycle while out_stall is low; each cell frees as soon as its neighbor takes its item.
// in_stall rises only when all seven stages hold items and the output is stalled.
// Reset (rst, synchronous): empties every stage and sets power to 1.
module fresnel_power_multiply
  import fpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [FR_W-1:0]   fresnel_re,
  input  logic signed [FR_W-1:0]   fresnel_im,
  input  logic signed [SKY_W-1:0]  sky_re,
  input  logic signed [SKY_W-1:0]  sky_im,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SKY_W-1:0]  out_re,
  output logic signed [SKY_W-1:0]  out_im,
  output logic                     left_unchanged,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [PWR_W-1:0] power;
  logic             reg_sel;

  // Chain links: index 0 is the block input, index k is the output of cell k-1
  stage_t           link  [0:NCELL];
  logic             lvalid[0:NCELL];
  logic             rdy   [0:NCELL];

  // ------------------------------------------------------------------
  // Configuration: one register, word index taken from paddr[2]
  // ------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_POWER);

  always_ff @(posedge clk) begin
    if (rst) begin
      power <= POWER_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      power <= pwdata[PWR_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32-PWR_W){1'b0}}, power} : 32'd0;

  // ------------------------------------------------------------------
  // Chain head: accumulator starts at 1.0, base at the Fresnel value.
  // A zero Fresnel value with power other than 1 marks the item for
  // pass-through; the cells still run but the output stage drops the product.
  // ------------------------------------------------------------------
  always_comb begin
    link[0].acc_re    = ONE_Q14;
    link[0].acc_im    = '0;
    link[0].base_re   = fresnel_re;
    link[0].base_im   = fresnel_im;
    link[0].sky_re    = sky_re;
    link[0].sky_im    = sky_im;
    link[0].unchanged = (power != POWER_RESET) && (fresnel_re == '0) && (fresnel_im == '0);
  end

  assign lvalid[0] = in_valid;
  assign in_stall  = !rdy[0];

  // ------------------------------------------------------------------
  // Power cells: cell k handles exponent bit k (multiply if set, square base)
  // ------------------------------------------------------------------
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    fpm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .pw_bit     (power[k]),
      .in_valid   (lvalid[k]),
      .d_in       (link[k]),
      .down_ready (rdy[k+1]),
      .up_ready   (rdy[k]),
      .valid      (lvalid[k+1]),
      .q          (link[k+1])
    );
  end

  // ------------------------------------------------------------------
  // Output stage: sky times the power value, registered result
  // ------------------------------------------------------------------
  fpm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lvalid[NCELL]),
    .d_in      (link[NCELL]),
    .up_ready  (rdy[NCELL]),
    .valid     (out_valid),
    .stall     (out_stall),
    .re        (out_re),
    .im        (out_im),
    .unchanged (left_unchanged)
  );

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // hold input back only when the whole chain is full behind a stalled output
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && lvalid[1] && lvalid[NCELL]))
    else $error("input stalled while the chain has room");

  // power comes out of reset at 1
  a_power_reset : assert property (@(posedge clk)
    $past(rst) |-> (power == POWER_RESET))
    else $error("power not at reset value after reset");

  // a new result only appears if the last cell held an item
  a_out_source : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(lvalid[NCELL]))
    else $error("output item appeared from an empty chain");

  // the last cell, when it holds an item and cannot move, keeps it
  a_cell_hold : assert property (@(posedge clk) disable iff (rst)
    (lvalid[NCELL] && !rdy[NCELL]) |=> lvalid[NCELL])
    else $error("last cell lost an item while blocked");

endmodule

// ===== tb/fresnel_product_checker.sv =====
`timescale 1ns / 1ps

module fresnel_product_checker
  import fpm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [FR_W-1:0]  fresnel_re,
  input  logic signed [FR_W-1:0]  fresnel_im,
  input  logic signed [SKY_W-1:0] sky_re,
  input  logic signed [SKY_W-1:0] sky_im,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [SKY_W-1:0] out_re,
  input  logic signed [SKY_W-1:0] out_im,
  input  logic                    left_unchanged,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output int                      errors,
  output int                      pending,
  output int                      checked,
  output int                      passed_through
);

  localparam logic [2:0] POWER_ADDR = 3'(4 * REG_POWER);
  localparam longint Q14_MAX = (longint'(1) <<< (FR_W - 1)) - 1;
  localparam longint Q14_MIN = -(longint'(1) <<< (FR_W - 1));
  localparam longint SKY_MAX = (longint'(1) <<< (SKY_W - 1)) - 1;
  localparam longint SKY_MIN = -(longint'(1) <<< (SKY_W - 1));

  typedef struct packed {
    logic signed [SKY_W-1:0] re;
    logic signed [SKY_W-1:0] im;
    logic                    unchanged;
  } sky_result_t;

  sky_result_t      expected_sky[$];
  logic [PWR_W-1:0] power_q;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  // Exact complex product, round half up at the Q2.14 point, clamp each part.
  function automatic void complex_mul_round(input longint ar, input longint ai,
                                            input longint br, input longint bi,
                                            input longint lo, input longint hi,
                                            output longint rr, output longint ri);
    longint re;
    longint im;
    re = ((ar * br - ai * bi) + 8192) >>> FRAC;
    im = ((ar * bi + ai * br) + 8192) >>> FRAC;
    rr = (re < lo) ? lo : ((re > hi) ? hi : re);
    ri = (im < lo) ? lo : ((im > hi) ? hi : im);
  endfunction

  function automatic sky_result_t predict_weighted_sky(input logic signed [FR_W-1:0] fr,
                                                       input logic signed [FR_W-1:0] fi,
                                                       input logic signed [SKY_W-1:0] sr,
                                                       input logic signed [SKY_W-1:0] si,
                                                       input logic [PWR_W-1:0] pwr);
    longint      acc_re;
    longint      acc_im;
    longint      base_re;
    longint      base_im;
    longint      prod_re;
    longint      prod_im;
    sky_result_t r;
    if (pwr != 1 && fr == 0 && fi == 0) begin
      r.re = sr;
      r.im = si;
      r.unchanged = 1'b1;
      return r;
    end
    acc_re = ONE_Q14;
    acc_im = 0;
    base_re = fr;
    base_im = fi;
    // square-and-multiply, low exponent bit first
    for (int k = 0; k < PWR_W; k++) begin
      if (pwr[k]) begin
        complex_mul_round(acc_re, acc_im, base_re, base_im, Q14_MIN, Q14_MAX,
                          acc_re, acc_im);
      end
      complex_mul_round(base_re, base_im, base_re, base_im, Q14_MIN, Q14_MAX,
                        base_re, base_im);
    end
    complex_mul_round(sr, si, acc_re, acc_im, SKY_MIN, SKY_MAX, prod_re, prod_im);
    r.re = prod_re[SKY_W-1:0];
    r.im = prod_im[SKY_W-1:0];
    r.unchanged = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sky_result_t want;
    if (rst) begin
      power_q = POWER_RESET;
      expected_sky.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sky.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = expected_sky.pop_front();
          checked++;
          if (want.unchanged) begin
            passed_through++;
          end
          if (out_re !== want.re) begin
            report_mismatch($sformatf("out_re %0d, expected %0d", out_re, want.re));
          end
          if (out_im !== want.im) begin
            report_mismatch($sformatf("out_im %0d, expected %0d", out_im, want.im));
          end
          if (left_unchanged !== want.unchanged) begin
            report_mismatch($sformatf("left_unchanged %b, expected %b",
                                      left_unchanged, want.unchanged));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_sky.push_back(predict_weighted_sky(fresnel_re, fresnel_im, sky_re, sky_im,
                                                    power_q));
      end
      if (psel && penable && pwrite && pready && paddr == POWER_ADDR) begin
        power_q = pwdata[PWR_W-1:0];
      end
    end
    pending = expected_sky.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fpm_pkg::*;

  localparam int         RESET_CYCLES = 6;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 130;
  localparam logic [2:0] POWER_ADDR   = 3'(4 * REG_POWER);

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [FR_W-1:0]  fresnel_re;
  logic signed [FR_W-1:0]  fresnel_im;
  logic signed [SKY_W-1:0] sky_re;
  logic signed [SKY_W-1:0] sky_im;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SKY_W-1:0] out_re;
  logic signed [SKY_W-1:0] out_im;
  logic                    left_unchanged;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  int errors;
  int pending;
  int checked;
  int passed_through;
  int items_sent;
  int power_writes;
  int cycle_count = 0;
  bit no_idle;            // when set, neither side inserts gaps or stalls

  always #10 clk = ~clk;

  fresnel_power_multiply DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .fresnel_re(fresnel_re), .fresnel_im(fresnel_im), .sky_re(sky_re), .sky_im(sky_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_re(out_re), .out_im(out_im), .left_unchanged(left_unchanged),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fresnel_product_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .fresnel_re(fresnel_re), .fresnel_im(fresnel_im), .sky_re(sky_re), .sky_im(sky_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_re(out_re), .out_im(out_im), .left_unchanged(left_unchanged),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending), .checked(checked),
    .passed_through(passed_through)
  );

  // Hard stop in case the block hangs on a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one item after a random gap, then hold it until the block takes it.
  // Valid stays high across back-to-back items; only the payload moves.
  task automatic send_item(input logic signed [FR_W-1:0] fr, input logic signed [FR_W-1:0] fi,
                           input logic signed [SKY_W-1:0] sr,
                           input logic signed [SKY_W-1:0] si);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    fresnel_re <= fr;
    fresnel_im <= fi;
    sky_re     <= sr;
    sky_im     <= si;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding item to come back out.
  // Sample the checker's count on the falling edge, clear of its update.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic write_power(input logic [PWR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= POWER_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    power_writes++;
  endtask

  function automatic logic signed [FR_W-1:0] fresnel_corner();
    logic signed [FR_W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = -32768;
      1: v = -16384;
      2: v = -1;
      3: v = 0;
      4: v = 1;
      5: v = 16384;
      default: v = 32767;
    endcase
    return v;
  endfunction

  function automatic logic signed [SKY_W-1:0] sky_corner();
    logic signed [SKY_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = -8388608;
      1: v = 8388607;
      2: v = 0;
      default: v = -1;
    endcase
    return v;
  endfunction

  // Mix of zero Fresnel values, half-zero values, corners, near-unit values and
  // fully random bits, so every exponent path and both saturation bounds are hit.
  task automatic send_random_item();
    logic signed [FR_W-1:0]  fr;
    logic signed [FR_W-1:0]  fi;
    logic signed [SKY_W-1:0] sr;
    logic signed [SKY_W-1:0] si;
    case ($urandom_range(0, 9))
      0: begin
        fr = 0;
        fi = 0;
      end
      1: begin
        fr = 0;
        fi = FR_W'($urandom);
        if ($urandom_range(0, 1)) begin
          fr = fi;
          fi = 0;
        end
      end
      2: begin
        fr = fresnel_corner();
        fi = fresnel_corner();
      end
      3, 4: begin
        fr = FR_W'(int'($urandom_range(0, 32768)) - 16384);
        fi = FR_W'(int'($urandom_range(0, 32768)) - 16384);
      end
      default: begin
        fr = FR_W'($urandom);
        fi = FR_W'($urandom);
      end
    endcase
    sr = ($urandom_range(0, 7) == 0) ? sky_corner() : SKY_W'($urandom);
    si = ($urandom_range(0, 7) == 0) ? sky_corner() : SKY_W'($urandom);
    send_item(fr, fi, sr, si);
  endtask

  // Result side: stall a random number of cycles before each result.
  initial begin : result_sink
    int stall_cycles;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall_cycles = no_idle ? 0 : $urandom_range(0, 4);
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [PWR_W-1:0] phase_power;
    no_idle     = 1'b0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    fresnel_re <= '0;
    fresnel_im <= '0;
    sky_re     <= '0;
    sky_im     <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset power of one: zero Fresnel still multiplies, unit passes, corners saturate.
    send_item(0, 0, 1000, -1000);
    send_item(16384, 0, 8388607, -8388608);
    send_item(32767, 32767, 8388607, 8388607);
    send_item(-32768, -32768, -8388608, 8388607);
    send_item(-32768, 0, -8388608, -8388608);
    send_item(0, 16384, 12345, -6789);
    send_item(1, -1, 1, -1);
    drain_results();

    // Power zero: a nonzero value is exactly one, a zero value raises the flag.
    write_power(0);
    send_item(12345, -2000, 8388607, -8388608);
    send_item(0, 0, -5, 5);
    send_item(0, 1, 77, -77);
    drain_results();

    // Top power: intermediates saturate.
    write_power(63);
    send_item(32767, 0, 1000000, -1000000);
    send_item(-32768, -32768, 8388607, 8388607);
    send_item(0, 0, 8388607, -8388608);
    send_item(11585, 11585, 4000000, 4000000);
    drain_results();

    write_power(2);
    send_item(0, 0, 0, 0);
    send_item(16384, 16384, 8388607, 8388607);
    send_item(8192, 0, -8388608, 3);
    drain_results();

    // Only the top exponent bit set.
    write_power(32);
    send_item(16384, 1, 100, 100);
    send_item(-16384, 0, -8388608, 8388607);
    drain_results();

    // Random phases, each at one power; extremes and the reset value come first.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: phase_power = 1;
        1: phase_power = 0;
        2: phase_power = 63;
        3: phase_power = 2;
        default: phase_power = PWR_W'($urandom_range(0, 63));
      endcase
      write_power(phase_power);
      no_idle = (phase == 0) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // in odd phases, hold off mid-phase until the pipeline has fully emptied
        if (n == PHASE_ITEMS / 2 && phase % 2 == 1) begin
          drain_results();
        end
        send_random_item();
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Sent %0d Fresnel/sky items across %0d power writes, powers 0 through 63.",
             items_sent, power_writes);
    $display("Checked %0d results, %0d of them sky passed through on a zero Fresnel value.",
             checked, passed_through);
    if (pending != 0) begin
      $display("%0d expected results never came out", pending);
    end
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fpm_pkg.sv
hw/rtl/fpm_cell.sv
hw/rtl/fpm_out.sv
hw/rtl/fresnel_power_multiply.sv
tb/fresnel_product_checker.sv
tb/tb.sv
